// ===== design/mm_pkg.sv =====
`default_nettype none

package mm_pkg;

   // Largest matrix side supported by default.
   localparam int unsigned MAX_DIM_DEFAULT = 8;

   // Width of the configuration registers and of the write port data.
   localparam int unsigned CSR_DATA_W = 4;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_COLS = 2'd2;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 4'd8;

   localparam logic [1:0] CMD_LOAD_LEFT = 2'd0;
   localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_ZERO_DIM = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] row_index;
      logic [2:0] col_index;
      logic signed [31:0] entry_value;
   } mm_req_type;

   typedef struct packed {
      logic [2:0] out_row;
      logic [2:0] out_col;
      logic signed [31:0] out_value;
      logic overflow;
      logic status;
      logic last;
   } mm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } mm_state_type;

   // Control from the sequencer to the multiply-accumulate unit and output stage.
   typedef struct packed {
      logic issue;
      logic round;
      logic emit;
      logic last;
   } mm_ctl_type;

endpackage

`default_nettype wire

// ===== design/mm_store.sv =====
`default_nettype none

module mm_store #(
   parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input wire logic clock,
   input wire logic we_left,
   input wire logic we_right,
   input wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
   input wire logic signed [31:0] wr_data,
   input wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_left,
   input wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_right,
   output logic signed [31:0] rd_left,
   output logic signed [31:0] rd_right
);

   localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

   logic signed [31:0] left_store_ff [DEPTH];
   logic signed [31:0] right_store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we_left) begin
         left_store_ff[wr_addr] <= wr_data;
      end
      rd_left <= left_store_ff[rd_addr_left];
   end

   always_ff @(posedge clock) begin
      if (we_right) begin
         right_store_ff[wr_addr] <= wr_data;
      end
      rd_right <= right_store_ff[rd_addr_right];
   end

endmodule

`default_nettype wire

// ===== design/mm_mac.sv =====
`default_nettype none

module mm_mac #(
   parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire mm_pkg::mm_ctl_type ctl,
   input wire logic signed [31:0] left_data,
   input wire logic signed [31:0] right_data,
   output logic pipe_busy,
   output logic signed [31:0] value,
   output logic overflow
);

   // The exact sum of up to MAX_DIM full Q32.32 products.
   localparam int unsigned ACC_W = 64 + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
   localparam int unsigned RW = ACC_W - 15;

   logic rd_v_ff;
   logic mul_v_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [RW-1:0] rounded_ff;
   logic signed [RW-1:0] rounded_in;
   logic signed [ACC_W-17:0] floor_val;
   logic [15:0] frac;
   logic round_up;
   logic in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= ctl.issue;
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= left_data * right_data;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.round) begin
         acc_in = '0;
      end else if (mul_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Round to nearest, ties away from zero, judged on the sign of the floor.
   always_comb begin
      floor_val = acc_ff[ACC_W-1:16];
      frac = acc_ff[15:0];
      if (!acc_ff[ACC_W-1]) begin
         round_up = frac[15];
      end else begin
         round_up = (frac > 16'h8000);
      end
      rounded_in = RW'(floor_val) + RW'({1'b0, round_up});
   end

   always_ff @(posedge clock) begin
      if (ctl.round) begin
         rounded_ff <= rounded_in;
      end
   end

   always_comb begin
      in_range = (rounded_ff[RW-1:31] == '0) || (rounded_ff[RW-1:31] == '1);
      overflow = !in_range;
      if (in_range) begin
         value = rounded_ff[31:0];
      end else if (rounded_ff[RW-1]) begin
         value = 32'sh8000_0000;
      end else begin
         value = 32'sh7FFF_FFFF;
      end
   end

   assign pipe_busy = rd_v_ff || mul_v_ff;

`ifndef ASSERT_OFF
   a_round_after_drain: assert property (@(posedge clock) disable iff (reset)
      ctl.round |-> !pipe_busy)
      else $error("rounding started while products were still in flight");
`endif

endmodule

`default_nettype wire

// ===== design/mm_seq.sv =====
`default_nettype none

module mm_seq #(
   parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic go,
   input wire logic [$clog2(MAX_DIM + 1)-1:0] dim_m,
   input wire logic [$clog2(MAX_DIM + 1)-1:0] dim_n,
   input wire logic [$clog2(MAX_DIM + 1)-1:0] dim_p,
   input wire logic pipe_busy,
   output mm_pkg::mm_ctl_type ctl,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] addr_left,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] addr_right,
   output logic [2:0] row,
   output logic [2:0] col,
   output logic busy
);

   localparam int unsigned DW = $clog2(MAX_DIM + 1);
   localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

   mm_pkg::mm_state_type state_ff;
   mm_pkg::mm_state_type state_in;
   logic [IW-1:0] r_ff;
   logic [IW-1:0] r_in;
   logic [IW-1:0] c_ff;
   logic [IW-1:0] c_in;
   logic [IW-1:0] k_ff;
   logic [IW-1:0] k_in;
   logic last_k;
   logic last_c;
   logic last_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
         r_ff <= '0;
         c_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         r_ff <= r_in;
         c_ff <= c_in;
         k_ff <= k_in;
      end
   end

   assign last_k = (DW'(k_ff) == dim_n - DW'(1));
   assign last_c = (DW'(c_ff) == dim_p - DW'(1));
   assign last_r = (DW'(r_ff) == dim_m - DW'(1));

   always_comb begin
      state_in = state_ff;
      r_in = r_ff;
      c_in = c_ff;
      k_in = k_ff;
      ctl = '0;
      unique case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (go) begin
               r_in = '0;
               c_in = '0;
               k_in = '0;
               state_in = mm_pkg::ST_FETCH;
            end
         end
         mm_pkg::ST_FETCH: begin
            ctl.issue = 1'b1;
            if (last_k) begin
               k_in = '0;
               state_in = mm_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = mm_pkg::ST_ROUND;
            end
         end
         mm_pkg::ST_ROUND: begin
            ctl.round = 1'b1;
            state_in = mm_pkg::ST_EMIT;
         end
         mm_pkg::ST_EMIT: begin
            ctl.emit = 1'b1;
            ctl.last = last_r && last_c;
            if (last_r && last_c) begin
               state_in = mm_pkg::ST_IDLE;
            end else begin
               state_in = mm_pkg::ST_FETCH;
               if (last_c) begin
                  c_in = '0;
                  r_in = r_ff + IW'(1);
               end else begin
                  c_in = c_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

   assign addr_left = AW'(int'(r_ff) * MAX_DIM + int'(k_ff));
   assign addr_right = AW'(int'(k_ff) * MAX_DIM + int'(c_ff));
   assign row = 3'(r_ff);
   assign col = 3'(c_ff);
   assign busy = (state_ff != mm_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== design/matrix_multiply.sv =====
`default_nettype none

// Matrix multiplier over signed Q16.16 entries. Load items write one entry of
// the left or right store, and loads may follow each other in every cycle
// while busy is low; a load with a row or column outside the store is
// dropped. A compute item makes the block busy while it walks the product in
// row-major order through one shared multiplier and a wide accumulator: each
// product entry takes one store read per inner step, then the multiply and
// accumulate pipeline drains, the sum is rounded and the entry is saturated.
// Every result is presented for exactly one cycle with rsp_strobe and must be
// taken then, as the receiver cannot hold it off. A compute item with any
// dimension of zero gives one error item on the following cycle without
// raising busy. Registers above MAX_DIM act as MAX_DIM, and must only be
// written while busy is low.
module matrix_multiply #(
   parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [mm_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [mm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input wire logic start,
   output logic busy,
   input wire mm_pkg::mm_req_type req_data,
   output logic rsp_strobe,
   output mm_pkg::mm_rsp_type rsp_data
);

   localparam int unsigned DW = $clog2(MAX_DIM + 1);
   localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam logic [mm_pkg::CSR_DATA_W-1:0] DIM_MAX = mm_pkg::CSR_DATA_W'(MAX_DIM);

   logic [mm_pkg::CSR_DATA_W-1:0] left_rows_ff;
   logic [mm_pkg::CSR_DATA_W-1:0] inner_size_ff;
   logic [mm_pkg::CSR_DATA_W-1:0] right_cols_ff;
   logic [DW-1:0] dim_m;
   logic [DW-1:0] dim_n;
   logic [DW-1:0] dim_p;
   logic accept;
   logic in_range;
   logic we_left;
   logic we_right;
   logic compute;
   logic zero_dim;
   logic go;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] addr_left;
   logic [AW-1:0] addr_right;
   logic signed [31:0] rd_left;
   logic signed [31:0] rd_right;
   logic pipe_busy;
   logic signed [31:0] mac_value;
   logic mac_overflow;
   logic [2:0] seq_row;
   logic [2:0] seq_col;
   mm_pkg::mm_ctl_type ctl;
   logic rsp_strobe_ff;
   mm_pkg::mm_rsp_type rsp_ff;
   mm_pkg::mm_rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff <= mm_pkg::DIM_RESET;
         inner_size_ff <= mm_pkg::DIM_RESET;
         right_cols_ff <= mm_pkg::DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mm_pkg::CSR_LEFT_ROWS: left_rows_ff <= csr_wdata;
            mm_pkg::CSR_INNER_SIZE: inner_size_ff <= csr_wdata;
            mm_pkg::CSR_RIGHT_COLS: right_cols_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign dim_m = DW'((left_rows_ff > DIM_MAX) ? DIM_MAX : left_rows_ff);
   assign dim_n = DW'((inner_size_ff > DIM_MAX) ? DIM_MAX : inner_size_ff);
   assign dim_p = DW'((right_cols_ff > DIM_MAX) ? DIM_MAX : right_cols_ff);

   assign accept = start && !busy;
   assign in_range = (int'(req_data.row_index) < MAX_DIM) &&
                     (int'(req_data.col_index) < MAX_DIM);
   assign we_left = accept && in_range && (req_data.cmd == mm_pkg::CMD_LOAD_LEFT);
   assign we_right = accept && in_range && (req_data.cmd == mm_pkg::CMD_LOAD_RIGHT);
   assign wr_addr = AW'(int'(req_data.row_index) * MAX_DIM + int'(req_data.col_index));
   assign compute = accept && (req_data.cmd == mm_pkg::CMD_COMPUTE);
   assign zero_dim = (dim_m == '0) || (dim_n == '0) || (dim_p == '0);
   assign go = compute && !zero_dim;

   mm_store #(
      .MAX_DIM(MAX_DIM)
   ) u_store (
      .clock(clock),
      .we_left(we_left),
      .we_right(we_right),
      .wr_addr(wr_addr),
      .wr_data(req_data.entry_value),
      .rd_addr_left(addr_left),
      .rd_addr_right(addr_right),
      .rd_left(rd_left),
      .rd_right(rd_right)
   );

   mm_seq #(
      .MAX_DIM(MAX_DIM)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .go(go),
      .dim_m(dim_m),
      .dim_n(dim_n),
      .dim_p(dim_p),
      .pipe_busy(pipe_busy),
      .ctl(ctl),
      .addr_left(addr_left),
      .addr_right(addr_right),
      .row(seq_row),
      .col(seq_col),
      .busy(busy)
   );

   mm_mac #(
      .MAX_DIM(MAX_DIM)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .left_data(rd_left),
      .right_data(rd_right),
      .pipe_busy(pipe_busy),
      .value(mac_value),
      .overflow(mac_overflow)
   );

   // A zero-dimension compute item is only accepted while idle, so it never meets an emit.
   always_comb begin
      rsp_in = '0;
      if (ctl.emit) begin
         rsp_in.out_row = seq_row;
         rsp_in.out_col = seq_col;
         rsp_in.out_value = mac_value;
         rsp_in.overflow = mac_overflow;
         rsp_in.status = mm_pkg::STATUS_OK;
         rsp_in.last = ctl.last;
      end else begin
         rsp_in.status = mm_pkg::STATUS_ZERO_DIM;
         rsp_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.emit || (compute && zero_dim);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == mm_pkg::STATUS_ZERO_DIM) |-> rsp_data.last)
      else $error("error item not marked as the last of its run");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("still busy after the last item of a run");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("run stopped before its last item");

   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && ($past(req_data.cmd) == mm_pkg::CMD_COMPUTE))
      else $error("busy rose without an accepted compute item");
`endif

endmodule

`default_nettype wire
